### rtl/core/dgd_pkg.sv
// Shared types and constants of the directed graph walk engine.
// Used by the controller, the datapath and the top level. No dependencies.
package dgd_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned OpW   = 3;
  localparam int unsigned VtxW  = 4;
  localparam int unsigned StatW = 3;

  // A walk gives at most this many result items
  localparam int unsigned ResultCap = 16;
  localparam int unsigned NumW      = $clog2(ResultCap + 1);

  typedef enum logic [OpW-1:0] {
    OP_ADD_VERTEX = 3'd0,
    OP_ADD_EDGE   = 3'd1,
    OP_DEL_EDGE   = 3'd2,
    OP_FIND_EDGE  = 3'd3,
    OP_WALK       = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_RANGE      = 3'd1,
    ST_LIST_FULL  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_e;

  // Kind of result placed into the pending slot
  typedef enum logic [1:0] {
    RES_PLAIN,   // status only
    RES_FOUND,   // edge found
    RES_VISIT    // newly visited vertex
  } res_e;

  // Neighbour count writes
  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_NEW,     // count of the vertex being added := 0
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;        // take in the input item
    logic    cnt_rd;      // read neighbour count of current vertex
    cnt_op_e cnt_op;
    logic    cnt_latch;   // keep count read data
    logic    idx_clr;
    logic    idx_inc;
    logic    tgt_rd;      // read neighbour at idx (or idx+1)
    logic    tgt_rd_next;
    logic    tgt_wr_add;  // append target at end of list
    logic    tgt_wr_shift;// move read neighbour down to idx
    logic    walk_init;   // clear marks, push start vertex
    logic    push;        // push read neighbour
    logic    pop;
    logic    cur_load;    // current vertex := popped entry
    logic    visit;       // mark current vertex visited
    logic    post;        // new pending result, older one goes out
    logic    post_keep;   // overwrite pending result in place
    res_e    res_kind;
    status_e res_status;
    logic    flush;       // send pending result as the last one
  } dgd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic src_ok;
    logic tgt_ok;
    logic table_full;
    logic list_full;
    logic idx_end;
    logic shift_end;
    logic match;
    logic cur_visited;
    logic nb_visited;
    logic sp_zero;
    logic sp_full;
    logic n_cap;
    logic out_free;
    logic pend_valid;
  } dgd_stat_t;

endpackage

### rtl/core/dgd_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dgd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/dgd_ctrl.sv
// Sequencer of the graph walk engine: steps each item through its operation.
// Depends on dgd_pkg; drives dgd_dp through command and status structs.
module dgd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dgd_pkg::dgd_stat_t stat_i,
  output dgd_pkg::dgd_cmd_t  cmd_o
);
  import dgd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CNT_WAIT,
    S_ADD_CHK,
    S_SCAN,
    S_SCAN_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_POP,
    S_POP_WAIT,
    S_VISIT,
    S_WCNT,
    S_NB,
    S_NB_CHK,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_kind   = RES_PLAIN;
    cmd_o.res_status = ST_OK;
    cmd_o.cnt_op     = CNT_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.op)
          OP_ADD_VERTEX: begin
            cmd_o.post = 1'b1;
            if (stat_i.table_full) begin
              cmd_o.res_status = ST_TABLE_FULL;
            end else begin
              cmd_o.cnt_op = CNT_NEW;
            end
            state_d = S_FLUSH;
          end
          OP_ADD_EDGE, OP_DEL_EDGE, OP_FIND_EDGE: begin
            if (!(stat_i.src_ok && stat_i.tgt_ok)) begin
              cmd_o.post       = 1'b1;
              cmd_o.res_status = ST_RANGE;
              state_d          = S_FLUSH;
            end else begin
              cmd_o.cnt_rd = 1'b1;
              state_d      = S_CNT_WAIT;
            end
          end
          OP_WALK: begin
            if (!stat_i.src_ok) begin
              cmd_o.post       = 1'b1;
              cmd_o.res_status = ST_RANGE;
              state_d          = S_FLUSH;
            end else begin
              cmd_o.walk_init = 1'b1;
              state_d         = S_POP;
            end
          end
          default: begin
            cmd_o.post = 1'b1;
            state_d    = S_FLUSH;
          end
        endcase
      end
      S_CNT_WAIT: begin
        cmd_o.cnt_latch = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        state_d = (stat_i.op == OP_ADD_EDGE) ? S_ADD_CHK : S_SCAN;
      end
      S_ADD_CHK: begin
        cmd_o.post = 1'b1;
        if (stat_i.list_full) begin
          cmd_o.res_status = ST_LIST_FULL;
        end else begin
          cmd_o.tgt_wr_add = 1'b1;
          cmd_o.cnt_op     = CNT_INC;
        end
        state_d = S_FLUSH;
      end
      // Linear search for the first match
      S_SCAN: begin
        if (stat_i.idx_end) begin
          cmd_o.post = 1'b1;
          state_d    = S_FLUSH;
        end else begin
          cmd_o.tgt_rd = 1'b1;
          state_d      = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat_i.match) begin
          cmd_o.post     = 1'b1;
          cmd_o.res_kind = RES_FOUND;
          state_d = (stat_i.op == OP_DEL_EDGE) ? S_SHIFT : S_FLUSH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN;
        end
      end
      // Close the gap left by a deleted target
      S_SHIFT: begin
        if (stat_i.shift_end) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_FLUSH;
        end else begin
          cmd_o.tgt_rd      = 1'b1;
          cmd_o.tgt_rd_next = 1'b1;
          state_d           = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.tgt_wr_shift = 1'b1;
        cmd_o.idx_inc      = 1'b1;
        state_d            = S_SHIFT;
      end
      // Walk: pop, visit, push unvisited neighbours
      S_POP: begin
        if (stat_i.sp_zero) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd_o.cur_load = 1'b1;
        state_d        = S_VISIT;
      end
      S_VISIT: begin
        if (stat_i.cur_visited) begin
          cmd_o.cnt_rd = 1'b1;
          state_d      = S_WCNT;
        end else if (stat_i.n_cap) begin
          state_d = S_FLUSH;
        end else if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.visit    = 1'b1;
          cmd_o.post     = 1'b1;
          cmd_o.res_kind = RES_VISIT;
          cmd_o.cnt_rd   = 1'b1;
          state_d        = S_WCNT;
        end
      end
      S_WCNT: begin
        cmd_o.cnt_latch = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        state_d         = S_NB;
      end
      S_NB: begin
        if (stat_i.idx_end) begin
          state_d = S_POP;
        end else begin
          cmd_o.tgt_rd = 1'b1;
          state_d      = S_NB_CHK;
        end
      end
      S_NB_CHK: begin
        if (stat_i.nb_visited) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_NB;
        end else if (!stat_i.sp_full) begin
          cmd_o.push    = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d       = S_NB;
        end else if (stat_i.n_cap) begin
          // overflow result takes the place of the last visit
          cmd_o.post_keep  = 1'b1;
          cmd_o.res_status = ST_OVERFLOW;
          state_d          = S_FLUSH;
        end else if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.post       = 1'b1;
          cmd_o.res_status = ST_OVERFLOW;
          state_d          = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/dgd_dp.sv
// Datapath of the graph walk engine: graph store, walk stack, visited marks,
// pending result and output register. Depends on dgd_pkg and dgd_ram.
module dgd_dp #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_DEGREE   = 8,
  parameter int unsigned STACK_DEPTH  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dgd_pkg::OpW-1:0]      in_op_i,
  input  logic [dgd_pkg::VtxW-1:0]     in_src_i,
  input  logic [dgd_pkg::VtxW-1:0]     in_tgt_i,
  input  dgd_pkg::dgd_cmd_t            cmd_i,
  output dgd_pkg::dgd_stat_t           stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [dgd_pkg::VtxW-1:0]     out_vtx_o,
  output logic                         out_found_o,
  output logic [dgd_pkg::StatW-1:0]    out_status_o,
  output logic                         out_last_o
);
  import dgd_pkg::*;

  localparam int unsigned VW   = $clog2(MAX_VERTICES);
  localparam int unsigned CW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW   = (CW > VtxW) ? CW : VtxW;
  localparam int unsigned IW   = $clog2(MAX_DEGREE + 1);
  localparam int unsigned TD   = MAX_VERTICES * MAX_DEGREE;
  localparam int unsigned TAW  = $clog2(TD);
  localparam int unsigned SAW  = $clog2(STACK_DEPTH);
  localparam int unsigned SW   = $clog2(STACK_DEPTH + 1);

  // Item and walk registers
  op_e              op_q;
  logic [VtxW-1:0]  src_q, tgt_q, cur_q;
  logic [CW-1:0]    vc_q;
  logic [SW-1:0]    sp_q;
  logic [NumW-1:0]  n_q;
  logic [IW-1:0]    idx_q, cnt_q;
  logic [MAX_VERTICES-1:0] vis_q;

  // Pending result and output register
  logic             pend_valid_q;
  logic [VtxW-1:0]  pend_vtx_q;
  logic             pend_found_q;
  logic [StatW-1:0] pend_status_q;
  logic             out_valid_q;
  logic [VtxW-1:0]  out_vtx_q;
  logic             out_found_q;
  logic [StatW-1:0] out_status_q;
  logic             out_last_q;

  logic             out_free;
  logic [VtxW-1:0]  tg_rdata, st_rdata;
  logic [IW-1:0]    cn_rdata;

  // Memory port signals
  logic             cn_we;
  logic [VW-1:0]    cn_waddr;
  logic [IW-1:0]    cn_wdata;
  logic [TAW-1:0]   list_base, tg_raddr, tg_waddr;
  logic [VtxW-1:0]  tg_wdata;
  logic             st_we;
  logic [SAW-1:0]   st_waddr, st_raddr;
  logic [VtxW-1:0]  st_wdata;
  logic [SW-1:0]    sp_dec;

  assign out_free = !out_valid_q || out_ready_i;
  assign sp_dec   = sp_q - SW'(1);

  // Neighbour count store
  always_comb begin
    cn_we    = (cmd_i.cnt_op != CNT_NONE);
    cn_waddr = VW'(cur_q);
    cn_wdata = '0;
    case (cmd_i.cnt_op)
      CNT_NEW: cn_waddr = VW'(vc_q);
      CNT_INC: cn_wdata = cnt_q + IW'(1);
      CNT_DEC: cn_wdata = cnt_q - IW'(1);
      default: cn_wdata = '0;
    endcase
  end

  dgd_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_counts (
    .clk_i   (clk_i),
    .we_i    (cn_we),
    .waddr_i (cn_waddr),
    .wdata_i (cn_wdata),
    .re_i    (cmd_i.cnt_rd),
    .raddr_i (VW'(cur_q)),
    .rdata_o (cn_rdata)
  );

  // Neighbour target store, one row of MAX_DEGREE per vertex
  assign list_base = TAW'(VW'(cur_q)) * TAW'(MAX_DEGREE);
  assign tg_raddr  = list_base + TAW'(cmd_i.tgt_rd_next ? idx_q + IW'(1) : idx_q);
  assign tg_waddr  = list_base + TAW'(cmd_i.tgt_wr_add ? cnt_q : idx_q);
  assign tg_wdata  = cmd_i.tgt_wr_add ? tgt_q : tg_rdata;

  dgd_ram #(.WIDTH(VtxW), .DEPTH(TD)) u_targets (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tgt_wr_add | cmd_i.tgt_wr_shift),
    .waddr_i (tg_waddr),
    .wdata_i (tg_wdata),
    .re_i    (cmd_i.tgt_rd),
    .raddr_i (tg_raddr),
    .rdata_o (tg_rdata)
  );

  // Walk stack
  assign st_we    = cmd_i.walk_init | cmd_i.push;
  assign st_waddr = cmd_i.walk_init ? '0 : sp_q[SAW-1:0];
  assign st_wdata = cmd_i.walk_init ? src_q : tg_rdata;
  assign st_raddr = sp_dec[SAW-1:0];

  dgd_ram #(.WIDTH(VtxW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (cmd_i.pop),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Status to the controller
  always_comb begin
    stat_o.op          = op_q;
    stat_o.src_ok      = XW'(src_q) < XW'(vc_q);
    stat_o.tgt_ok      = XW'(tgt_q) < XW'(vc_q);
    stat_o.table_full  = (vc_q == CW'(MAX_VERTICES));
    stat_o.list_full   = (cnt_q == IW'(MAX_DEGREE));
    stat_o.idx_end     = (idx_q >= cnt_q);
    stat_o.shift_end   = ((idx_q + IW'(1)) >= cnt_q);
    stat_o.match       = (tg_rdata == tgt_q);
    stat_o.cur_visited = vis_q[VW'(cur_q)];
    stat_o.nb_visited  = vis_q[VW'(tg_rdata)];
    stat_o.sp_zero     = (sp_q == '0);
    stat_o.sp_full     = (sp_q == SW'(STACK_DEPTH));
    stat_o.n_cap       = (n_q >= NumW'(ResultCap));
    stat_o.out_free    = out_free;
    stat_o.pend_valid  = pend_valid_q;
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(in_op_i);
      src_q <= in_src_i;
      tgt_q <= in_tgt_i;
    end
    if (cmd_i.load) begin
      cur_q <= in_src_i;
    end else if (cmd_i.cur_load) begin
      cur_q <= st_rdata;
    end
    if (cmd_i.cnt_latch) begin
      cnt_q <= cn_rdata;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // Control registers: vertex count, stack pointer, marks, result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= '0;
      sp_q  <= '0;
      vis_q <= '0;
      n_q   <= '0;
    end else begin
      if (cmd_i.cnt_op == CNT_NEW) begin
        vc_q <= vc_q + CW'(1);
      end
      if (cmd_i.walk_init) begin
        sp_q <= SW'(1);
      end else if (cmd_i.push) begin
        sp_q <= sp_q + SW'(1);
      end else if (cmd_i.pop) begin
        sp_q <= sp_dec;
      end
      if (cmd_i.walk_init) begin
        vis_q <= '0;
      end else if (cmd_i.visit) begin
        vis_q[VW'(cur_q)] <= 1'b1;
      end
      if (cmd_i.load) begin
        n_q <= '0;
      end else if (cmd_i.post) begin
        n_q <= n_q + NumW'(1);
      end
    end
  end

  // Pending result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.post | cmd_i.post_keep) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush | cmd_i.load) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post | cmd_i.post_keep) begin
      pend_vtx_q    <= (cmd_i.res_kind == RES_VISIT) ? cur_q : '0;
      pend_found_q  <= (cmd_i.res_kind == RES_FOUND);
      pend_status_q <= cmd_i.res_status;
    end
  end

  // Output register: an earlier result leaves on post, the last on flush
  logic out_load;
  assign out_load = cmd_i.flush | (cmd_i.post & pend_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_vtx_q    <= pend_vtx_q;
      out_found_q  <= pend_found_q;
      out_status_q <= pend_status_q;
      out_last_q   <= cmd_i.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vtx_o    = out_vtx_q;
  assign out_found_o  = out_found_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

### rtl/core/directed_graph_dfs_engine.sv
// Directed graph store with depth-first walk. One item at a time.
// Find/delete edge scan and shift the list through the single target memory port; a
// walk pops, visits and pushes neighbours, and can be held by output stalls.
// A new item is taken while the last result of the previous one still waits.
// Reset (async, active low) empties the graph, the stack and the visited marks.
module directed_graph_dfs_engine #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_DEGREE   = 8,
  parameter int unsigned STACK_DEPTH  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [3:0] source_vertex, [7:4] target_vertex
  input  logic [2:0] s_axis_tuser,  // [2:0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [3:0] visited_vertex, [4] edge_found, [7:5] status
  output logic       m_axis_tlast
);
  import dgd_pkg::*;

  dgd_cmd_t         cmd;
  dgd_stat_t        stat;
  logic [VtxW-1:0]  out_vtx;
  logic             out_found;
  logic [StatW-1:0] out_status;

  dgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dgd_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser),
    .in_src_i     (s_axis_tdata[3:0]),
    .in_tgt_i     (s_axis_tdata[7:4]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_vtx_o    (out_vtx),
    .out_found_o  (out_found),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_status, out_found, out_vtx};

endmodule

### tb/directed_graph_dfs_engine_tb.sv
// Testbench for directed_graph_dfs_engine: a queued stream driver, a result monitor and
// a built-in graph predictor that checks every result item field by field.
// Depends on dgd_pkg and the engine RTL only.
`timescale 1ns / 100ps

module directed_graph_dfs_engine_tb;
  import dgd_pkg::*;

  localparam int NumVtx   = 16;
  localparam int MaxDeg   = 8;
  localparam int StackDep = 64;

  typedef struct {
    logic [2:0] op;
    logic [3:0] src;
    logic [3:0] tgt;
    bit         drain;  // hold until all results are in
  } cmd_t;

  typedef struct {
    logic [3:0] vtx;
    logic       found;
    logic [2:0] status;
    logic       last;
  } res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  cmd_t pend_q[$];
  res_t walk_res_q[$];
  int   err_cnt = 0;

  // Graph copy kept by the predictor
  int         g_vcount = 0;
  logic [3:0] g_adj[NumVtx][MaxDeg];
  int         g_deg[NumVtx];

  directed_graph_dfs_engine u_top (.*);

  always #4 clk_i = ~clk_i;

  task automatic post_res(logic [3:0] v, logic f, status_e st);
    res_t r;
    r.vtx = v; r.found = f; r.status = st; r.last = 1'b0;
    walk_res_q.insert(walk_res_q.size(), r);
  endtask

  // Work out the result items of one accepted command
  task automatic predict_graph_op(cmd_t c);
    bit   seen[NumVtx];
    int   stk[StackDep];
    int   sp, n, pos, s, t, base;
    bit   done;
    base = walk_res_q.size();
    n = 0;
    case (c.op)
      OP_ADD_VERTEX: begin
        if (g_vcount >= NumVtx) post_res(0, 0, ST_TABLE_FULL);
        else begin
          g_deg[g_vcount] = 0;
          g_vcount++;
          post_res(0, 0, ST_OK);
        end
      end
      OP_ADD_EDGE, OP_DEL_EDGE, OP_FIND_EDGE: begin
        if (c.src >= g_vcount || c.tgt >= g_vcount) post_res(0, 0, ST_RANGE);
        else if (c.op == OP_ADD_EDGE) begin
          if (g_deg[c.src] >= MaxDeg) post_res(0, 0, ST_LIST_FULL);
          else begin
            g_adj[c.src][g_deg[c.src]] = c.tgt;
            g_deg[c.src]++;
            post_res(0, 0, ST_OK);
          end
        end else begin
          pos = -1;
          for (int i = g_deg[c.src] - 1; i >= 0; i--)
            if (g_adj[c.src][i] == c.tgt) pos = i;
          post_res(0, pos >= 0, ST_OK);
          if (pos >= 0 && c.op == OP_DEL_EDGE) begin
            for (int i = pos; i + 1 < g_deg[c.src]; i++)
              g_adj[c.src][i] = g_adj[c.src][i + 1];
            g_deg[c.src]--;
          end
        end
      end
      OP_WALK: begin
        if (c.src >= g_vcount) post_res(0, 0, ST_RANGE);
        else begin
          foreach (seen[i]) seen[i] = 0;
          sp = 1;
          stk[0] = c.src;
          done = 0;
          while (sp > 0 && !done) begin
            sp--;
            s = stk[sp];
            if (!seen[s]) begin
              if (n >= ResultCap) break;
              seen[s] = 1;
              post_res(s, 0, ST_OK);
              n++;
            end
            for (int i = 0; i < g_deg[s] && !done; i++) begin
              t = g_adj[s][i];
              if (!seen[t]) begin
                if (sp >= StackDep) begin
                  // overflow result replaces the last visit once the cap is hit
                  if (n >= ResultCap) void'(walk_res_q.pop_back());
                  post_res(0, 0, ST_OVERFLOW);
                  done = 1;
                end else begin
                  stk[sp] = t;
                  sp++;
                end
              end
            end
          end
        end
      end
      default: post_res(0, 0, ST_OK);
    endcase
    if (walk_res_q.size() == base) post_res(0, 0, ST_OK);
    walk_res_q[walk_res_q.size() - 1].last = 1'b1;
  endtask

  // Driver: presents queued items, predicts on acceptance
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit   busy;
    cmd_t c;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_gap        <= 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        c = pend_q.pop_front();
        predict_graph_op(c);
        busy = 0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap        <= in_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0 && pend_q.size() > 30 && $urandom_range(0, 9) == 0) begin
          in_gap        <= $urandom_range(0, 15);
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0 &&
                     (!pend_q[0].drain || (walk_res_q.size() == 0 && !s_axis_tvalid))) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pend_q[0].tgt, pend_q[0].src};
          s_axis_tuser  <= pend_q[0].op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compares against the oldest expectation
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_gap       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (walk_res_q.size() == 0) begin
          $display("%0t: unexpected result data=%h last=%b", $time, m_axis_tdata, m_axis_tlast);
          err_cnt++;
        end else begin
          e = walk_res_q.pop_front();
          if (m_axis_tdata[3:0] !== e.vtx || m_axis_tdata[4] !== e.found ||
              m_axis_tdata[7:5] !== e.status || m_axis_tlast !== e.last) begin
            $display("%0t: mismatch exp vtx=%0d found=%b status=%0d last=%b",
                     $time, e.vtx, e.found, e.status, e.last);
            $display("%0t:          got vtx=%0d found=%b status=%0d last=%b",
                     $time, m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[7:5],
                     m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap       <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (pend_q.size() > 30 && $urandom_range(0, 9) == 0) begin
        out_gap       <= $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void add_cmd(logic [2:0] op, logic [3:0] src, logic [3:0] tgt,
                                  bit drain = 0);
    cmd_t c;
    c.op = op; c.src = src; c.tgt = tgt; c.drain = drain;
    pend_q.insert(pend_q.size(), c);
  endfunction

  function automatic logic [3:0] pick_vtx(int vc);
    if (vc == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, vc - 1));
  endfunction

  // Stimulus and end of run
  initial begin
    int vc, r;
    logic [2:0] op;
    // directed: empty graph errors, unused codes, small graph with a cycle
    add_cmd(OP_WALK, 0, 0);
    add_cmd(OP_ADD_EDGE, 15, 15);
    add_cmd(3'd5, 0, 0);
    add_cmd(3'd6, 15, 15);
    add_cmd(3'd7, 5, 10);
    add_cmd(OP_ADD_VERTEX, 0, 0);
    add_cmd(OP_ADD_VERTEX, 15, 15);
    add_cmd(OP_ADD_VERTEX, 0, 0);
    add_cmd(OP_ADD_EDGE, 0, 1);
    add_cmd(OP_ADD_EDGE, 0, 1);
    add_cmd(OP_ADD_EDGE, 1, 2);
    add_cmd(OP_ADD_EDGE, 2, 0);
    add_cmd(OP_FIND_EDGE, 0, 1);
    add_cmd(OP_FIND_EDGE, 1, 0);
    add_cmd(OP_DEL_EDGE, 0, 1);
    add_cmd(OP_DEL_EDGE, 0, 2);
    add_cmd(OP_FIND_EDGE, 0, 15);
    add_cmd(OP_WALK, 0, 0, 1);
    add_cmd(OP_WALK, 2, 0);
    add_cmd(OP_WALK, 15, 0);
    vc = 3;
    // random: mostly in-range edges, graph grows until the table is full
    for (int k = 0; k < 280; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10)      op = OP_ADD_VERTEX;
      else if (r < 50) op = OP_ADD_EDGE;
      else if (r < 62) op = OP_DEL_EDGE;
      else if (r < 74) op = OP_FIND_EDGE;
      else if (r < 96) op = OP_WALK;
      else             op = 3'($urandom_range(5, 7));
      add_cmd(op, pick_vtx(vc), pick_vtx(vc), k == 140);
      if (op == OP_ADD_VERTEX && vc < NumVtx) vc++;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pend_q.size() == 0 && !s_axis_tvalid && walk_res_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && walk_res_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
